FILE: hdl/jalc_pkg.sv
// Shared types and constants for the joint angle block.
`default_nettype none
package jalc_pkg;
    localparam int SIDE_BITS    = 25;
    localparam int ANGLE_BITS   = 15;
    localparam int ZSCALE       = 20;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 30;
    localparam int XYW          = 56;
    localparam int RED_BITS     = 25;
    localparam int PROD_BITS    = 51;
    localparam int SUMSQ_BITS   = 52;

    typedef logic signed [XYW-1:0] t_xy;
    typedef logic signed [ZW-1:0]  t_z;

    // atan(2^-i) in units of 2^-20 degree
    function automatic t_z atan_of(input logic [4:0] i);
        t_z v;
        unique case (i)
            5'd0:  v = 30'sd47185920;
            5'd1:  v = 30'sd27855475;
            5'd2:  v = 30'sd14718068;
            5'd3:  v = 30'sd7471121;
            5'd4:  v = 30'sd3750058;
            5'd5:  v = 30'sd1876857;
            5'd6:  v = 30'sd938658;
            5'd7:  v = 30'sd469357;
            5'd8:  v = 30'sd234682;
            5'd9:  v = 30'sd117342;
            5'd10: v = 30'sd58671;
            5'd11: v = 30'sd29335;
            5'd12: v = 30'sd14668;
            5'd13: v = 30'sd7334;
            5'd14: v = 30'sd3667;
            5'd15: v = 30'sd1833;
            5'd16: v = 30'sd917;
            5'd17: v = 30'sd458;
            5'd18: v = 30'sd229;
            5'd19: v = 30'sd115;
            5'd20: v = 30'sd57;
            5'd21: v = 30'sd29;
            5'd22: v = 30'sd14;
            5'd23: v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/jalc_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
`default_nettype none
module jalc_sqrt_cell #(
    parameter int W   = 64,
    parameter int RW  = 33,
    parameter int TW  = 8,
    parameter int BIT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_rem,
    input  wire logic [RW-1:0] i_root,
    input  wire logic [TW-1:0] i_tag,
    output logic      [W-1:0]  o_rem,
    output logic      [RW-1:0] o_root,
    output logic      [TW-1:0] o_tag
);
    logic [W+1:0] w_trial;
    logic [W+1:0] w_rem;
    logic [RW-1:0] n_root;
    logic [W-1:0]  n_rem;

    // try setting this root bit: (root<<(BIT+1)) + (1<<(2*BIT))
    always_comb begin
        w_rem   = {2'b00, i_rem};
        w_trial = ({{(W+2-RW){1'b0}}, i_root} << (BIT + 1)) +
                  ((W+2)'(1) << (2 * BIT));
        if (w_rem >= w_trial) begin
            n_rem  = W'(w_rem - w_trial);
            n_root = i_root | (RW'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    // advance one stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
            o_tag  <= i_tag;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/jalc_sqrt_chain.sv
// Row of square root cells, one result bit per cell, with the tag carried alongside.
`default_nettype none
module jalc_sqrt_chain #(
    parameter int W  = 64,
    parameter int RW = 32,
    parameter int TW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_val,
    input  wire logic [TW-1:0] i_tag,
    output logic      [W-1:0]  o_rem,
    output logic      [RW-1:0] o_root,
    output logic      [TW-1:0] o_tag
);
    logic [W-1:0]  w_rem  [RW+1];
    logic [RW-1:0] w_root [RW+1];
    logic [TW-1:0] w_tag  [RW+1];

    assign w_rem[0]  = i_val;
    assign w_root[0] = '0;
    assign w_tag[0]  = i_tag;

    // cells run from the top root bit down
    for (genvar g = 0; g < RW; g++) begin : g_cell
        jalc_sqrt_cell #(.W(W), .RW(RW), .TW(TW), .BIT(RW - 1 - g)) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[g]),
            .i_root(w_root[g]),
            .i_tag (w_tag[g]),
            .o_rem (w_rem[g+1]),
            .o_root(w_root[g+1]),
            .o_tag (w_tag[g+1])
        );
    end

    assign o_rem  = w_rem[RW];
    assign o_root = w_root[RW];
    assign o_tag  = w_tag[RW];
endmodule
`default_nettype wire

FILE: hdl/jalc_cordic_cell.sv
// One vectoring CORDIC cell: rotate toward the x axis by atan(2^-STEP).
`default_nettype none
module jalc_cordic_cell #(
    parameter int STEP = 0,
    parameter int TW   = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire jalc_pkg::t_xy       i_x,
    input  wire jalc_pkg::t_xy       i_y,
    input  wire jalc_pkg::t_z        i_z,
    input  wire logic [TW-1:0]       i_tag,
    output jalc_pkg::t_xy            o_x,
    output jalc_pkg::t_xy            o_y,
    output jalc_pkg::t_z             o_z,
    output logic [TW-1:0]            o_tag
);
    jalc_pkg::t_xy w_xs;
    jalc_pkg::t_xy w_ys;
    jalc_pkg::t_z  w_a;

    assign w_xs = i_x >>> STEP;
    assign w_ys = i_y >>> STEP;
    assign w_a  = jalc_pkg::atan_of(5'(STEP));

    // advance one rotation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + w_a;
            end else begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - w_a;
            end
            o_tag <= i_tag;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/joint_angle_law_of_cosines.sv
// Top level: side lengths and middle joint angle of three 3-D joints.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------------------------
//  in      | i_valid  | o_stall  | i_first_*, i_middle_*, i_last_* (x, y, z)
//  out     | o_valid  | i_stall  | o_side_*, o_joint_angle, o_degenerate
//
// One item enters per cycle while the pipeline is not stalled. Stages: products (4),
// normalize (3), root cell row (32), CORDIC cell row (24), output rounding (1),
// and a second root row for the sides that runs in parallel and is padded.
// The whole pipeline advances when the output register is empty or taken; an
// output stall freezes every stage. Reset clears the valid bits only.
`default_nettype none
module joint_angle_law_of_cosines #(
    parameter int COORD_BITS      = 24,
    parameter int COORD_FRAC_BITS = 8,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_BITS-1:0]  i_first_x,
    input  wire logic signed [COORD_BITS-1:0]  i_first_y,
    input  wire logic signed [COORD_BITS-1:0]  i_first_z,
    input  wire logic signed [COORD_BITS-1:0]  i_middle_x,
    input  wire logic signed [COORD_BITS-1:0]  i_middle_y,
    input  wire logic signed [COORD_BITS-1:0]  i_middle_z,
    input  wire logic signed [COORD_BITS-1:0]  i_last_x,
    input  wire logic signed [COORD_BITS-1:0]  i_last_y,
    input  wire logic signed [COORD_BITS-1:0]  i_last_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [jalc_pkg::SIDE_BITS-1:0]     o_side_first_middle,
    output logic [jalc_pkg::SIDE_BITS-1:0]     o_side_middle_last,
    output logic [jalc_pkg::SIDE_BITS-1:0]     o_side_first_last,
    output logic [jalc_pkg::ANGLE_BITS-1:0]    o_joint_angle,
    output logic                               o_degenerate
);
    // the fractional bits only name the units of the coordinates
    localparam int DW   = COORD_BITS + 1;
    localparam int RED  = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
    localparam int RB   = jalc_pkg::RED_BITS;
    localparam int PB   = jalc_pkg::PROD_BITS;
    localparam int QB   = jalc_pkg::SUMSQ_BITS;
    localparam int SQW  = 2 * DW + 2;
    localparam int SRW  = SQW / 2;
    localparam int SB   = jalc_pkg::SIDE_BITS;
    localparam int ZS   = jalc_pkg::ZSCALE;
    localparam int NST  = jalc_pkg::CORDIC_STEPS;
    localparam int SH   = ZS - ANGLE_FRAC_BITS;
    localparam int FRNT = 7;
    localparam int ALAT = FRNT + 32 + NST;
    localparam int SLAT = 4 + SRW;
    localparam int PAD  = ALAT - SLAT;
    localparam int TOT  = ALAT + 1;
    localparam logic [SB-1:0] SMAX = '1;

    logic w_en;
    logic [TOT-1:0] r_vld;

    // whole pipe moves unless a finished item is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    // ---------------- stage 1: differences
    logic signed [DW-1:0] r_a [3];
    logic signed [DW-1:0] r_b [3];
    logic signed [DW-1:0] r_d [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a[0] <= DW'(i_first_x) - DW'(i_middle_x);
            r_a[1] <= DW'(i_first_y) - DW'(i_middle_y);
            r_a[2] <= DW'(i_first_z) - DW'(i_middle_z);
            r_b[0] <= DW'(i_last_x) - DW'(i_middle_x);
            r_b[1] <= DW'(i_last_y) - DW'(i_middle_y);
            r_b[2] <= DW'(i_last_z) - DW'(i_middle_z);
            r_d[0] <= DW'(i_last_x) - DW'(i_first_x);
            r_d[1] <= DW'(i_last_y) - DW'(i_first_y);
            r_d[2] <= DW'(i_last_z) - DW'(i_first_z);
        end
    end

    // ---------------- side squares: magnitudes saturate past the side range
    function automatic logic [DW-1:0] magn(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [SQW-1:0] r_sq [3][3];
    logic [2:0]     r_sat1;
    logic [SQW-1:0] r_ss [3];
    logic [2:0]     r_sat2;
    logic [DW-1:0]  w_m [3][3];
    logic [2:0]     w_big;

    always_comb begin
        for (int s = 0; s < 3; s++) begin
            w_m[0][s] = magn(r_a[s]);
            w_m[1][s] = magn(r_b[s]);
            w_m[2][s] = magn(r_d[s]);
        end
        for (int t = 0; t < 3; t++) begin
            w_big[t] = 1'b0;
            for (int s = 0; s < 3; s++)
                if ({{(64-DW){1'b0}}, w_m[t][s]} > 64'(SMAX)) w_big[t] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int t = 0; t < 3; t++) begin
                for (int s = 0; s < 3; s++)
                    r_sq[t][s] <= SQW'(w_m[t][s]) * SQW'(w_m[t][s]);
                r_ss[t] <= r_sq[t][0] + r_sq[t][1] + r_sq[t][2];
            end
            r_sat1 <= w_big;
            r_sat2 <= r_sat1;
        end
    end

    // ---------------- side roots: three chains of cells
    logic [SQW-1:0] w_srem [3];
    logic [SRW-1:0] w_sroot [3];
    logic [0:0]     w_stag [3];
    for (genvar t = 0; t < 3; t++) begin : g_side
        jalc_sqrt_chain #(.W(SQW), .RW(SRW), .TW(1)) u_sq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_val (r_ss[t]),
            .i_tag (r_sat2[t]),
            .o_rem (w_srem[t]),
            .o_root(w_sroot[t]),
            .o_tag (w_stag[t])
        );
    end

    // round to nearest and saturate, then delay to meet the angle path
    logic [SB-1:0] w_side [3];
    logic [SB-1:0] r_sdly [3][PAD+1];
    always_comb begin
        for (int t = 0; t < 3; t++) begin
            logic [SRW:0] rr;
            rr = {1'b0, w_sroot[t]} +
                 {{SRW{1'b0}}, (w_srem[t] > SQW'(w_sroot[t]))};
            if (w_stag[t][0] || rr > (SRW+1)'(SMAX)) w_side[t] = SMAX;
            else                                      w_side[t] = SB'(rr);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int t = 0; t < 3; t++) begin
                r_sdly[t][0] <= w_side[t];
                for (int k = 1; k <= PAD; k++) r_sdly[t][k] <= r_sdly[t][k-1];
            end
        end
    end

    // ---------------- angle front end
    // stage 2: reduce and degenerate flag
    logic signed [RB-1:0] r_u [3];
    logic signed [RB-1:0] r_v [3];
    logic                 r_dg [FRNT+32+NST-1];
    function automatic logic signed [RB-1:0] reduce(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = magn(v) >> RED;
        return v[DW-1] ? RB'(-$signed({1'b0, m})) : RB'(m);
    endfunction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 3; s++) begin
                r_u[s] <= reduce(r_a[s]);
                r_v[s] <= reduce(r_b[s]);
            end
            r_dg[0] <= (r_a[0] == 0 && r_a[1] == 0 && r_a[2] == 0) ||
                       (r_b[0] == 0 && r_b[1] == 0 && r_b[2] == 0);
            for (int k = 1; k < FRNT + 32 + NST - 1; k++) r_dg[k] <= r_dg[k-1];
        end
    end

    // stage 3: products
    logic signed [PB-1:0] r_p [12];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0]  <= PB'(r_u[0]) * PB'(r_v[0]);
            r_p[1]  <= PB'(r_u[1]) * PB'(r_v[1]);
            r_p[2]  <= PB'(r_u[2]) * PB'(r_v[2]);
            r_p[3]  <= PB'(r_u[1]) * PB'(r_v[2]);
            r_p[4]  <= PB'(r_u[2]) * PB'(r_v[1]);
            r_p[5]  <= PB'(r_u[2]) * PB'(r_v[0]);
            r_p[6]  <= PB'(r_u[0]) * PB'(r_v[2]);
            r_p[7]  <= PB'(r_u[0]) * PB'(r_v[1]);
            r_p[8]  <= PB'(r_u[1]) * PB'(r_v[0]);
            r_p[9]  <= '0;
            r_p[10] <= '0;
            r_p[11] <= '0;
        end
    end

    // stage 4: dot and cross magnitudes
    logic [PB:0] r_mg [4];
    logic        r_neg;
    function automatic logic [PB:0] mg(input logic signed [PB+1:0] v);
        return v[PB+1] ? (PB+1)'(-v) : (PB+1)'(v);
    endfunction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic signed [PB+1:0] dt;
            dt = (PB+2)'(r_p[0]) + (PB+2)'(r_p[1]) + (PB+2)'(r_p[2]) + (PB+2)'(r_p[9]);
            r_mg[0] <= mg(dt);
            r_neg   <= dt[PB+1];
            r_mg[1] <= mg((PB+2)'(r_p[3]) - (PB+2)'(r_p[4]) + (PB+2)'(r_p[10]));
            r_mg[2] <= mg((PB+2)'(r_p[5]) - (PB+2)'(r_p[6]) + (PB+2)'(r_p[11]));
            r_mg[3] <= mg((PB+2)'(r_p[7]) - (PB+2)'(r_p[8]));
        end
    end

    // stage 5: largest magnitude and its shift
    logic [PB:0] r_mg5 [4];
    logic        r_neg5;
    logic [5:0]  r_lead;
    logic        r_zero;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic [PB:0] o;
            logic [5:0]  ld;
            o  = r_mg[0] | r_mg[1] | r_mg[2] | r_mg[3];
            ld = '0;
            for (int k = 0; k <= PB; k++) if (o[k]) ld = 6'(k);
            r_lead <= ld;
            r_zero <= (o == '0);
            r_mg5  <= r_mg;
            r_neg5 <= r_neg;
        end
    end

    // stage 6: normalize so the top bit sits at bit 30
    logic [31:0] r_nm [4];
    logic        r_neg6;
    logic        r_zero6;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < 4; s++) begin
                if (r_lead >= 6'd30) r_nm[s] <= 32'(r_mg5[s] >> (r_lead - 6'd30));
                else                 r_nm[s] <= 32'(r_mg5[s] << (6'd30 - r_lead));
            end
            r_neg6  <= r_neg5;
            r_zero6 <= r_zero;
        end
    end

    // stage 7: sum of cross squares
    logic [63:0] r_cs;
    logic [31:0] r_dotn;
    logic [1:0]  r_fl7;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs   <= 64'(r_nm[1]) * 64'(r_nm[1]) + 64'(r_nm[2]) * 64'(r_nm[2]) +
                      64'(r_nm[3]) * 64'(r_nm[3]);
            r_dotn <= r_nm[0];
            r_fl7  <= {r_zero6, r_neg6};
        end
    end

    // cross magnitude root, dot magnitude and flags ride in the tag
    logic [63:0] w_crem;
    logic [31:0] w_croot;
    logic [33:0] w_ctag;
    jalc_sqrt_chain #(.W(64), .RW(32), .TW(34)) u_cross (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val (r_cs),
        .i_tag ({r_fl7, r_dotn}),
        .o_rem (w_crem),
        .o_root(w_croot),
        .o_tag (w_ctag)
    );

    // set up the vector, folding the left half plane by 90 degrees
    jalc_pkg::t_xy w_x [NST+1];
    jalc_pkg::t_xy w_y [NST+1];
    jalc_pkg::t_z  w_z [NST+1];
    logic          w_zt [NST+1];
    jalc_pkg::t_xy w_x0;
    jalc_pkg::t_xy w_y0;
    logic [63:0]   w_crem_unused;
    assign w_crem_unused = w_crem;
    assign w_x0 = jalc_pkg::t_xy'({1'b0, w_ctag[31:0]}) <<< ZS;
    assign w_y0 = jalc_pkg::t_xy'({1'b0, w_croot}) <<< ZS;
    always_comb begin
        if (w_ctag[32] && w_ctag[31:0] != '0) begin
            w_x[0] = w_y0;
            w_y[0] = w_x0;
            w_z[0] = jalc_pkg::t_z'(90) <<< ZS;
        end else begin
            w_x[0] = w_x0;
            w_y[0] = w_y0;
            w_z[0] = '0;
        end
        w_zt[0] = w_ctag[33];
    end

    for (genvar g = 0; g < NST; g++) begin : g_cordic
        jalc_cordic_cell #(.STEP(g), .TW(1)) u_cell (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_x  (w_x[g]),
            .i_y  (w_y[g]),
            .i_z  (w_z[g]),
            .i_tag(w_zt[g]),
            .o_x  (w_x[g+1]),
            .o_y  (w_y[g+1]),
            .o_z  (w_z[g+1]),
            .o_tag(w_zt[g+1])
        );
    end

    // clamp, round and register the result
    logic [jalc_pkg::ANGLE_BITS-1:0] w_ang;
    always_comb begin
        jalc_pkg::t_z zc;
        zc = w_z[NST];
        if (zc < 0) zc = '0;
        if (zc > (jalc_pkg::t_z'(180) <<< ZS)) zc = jalc_pkg::t_z'(180) <<< ZS;
        zc = (zc + (jalc_pkg::t_z'(1) <<< (SH - 1))) >>> SH;
        w_ang = (w_zt[NST] || r_dg[FRNT+32+NST-2]) ? '0 : jalc_pkg::ANGLE_BITS'(zc);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_side_first_middle <= r_sdly[0][PAD];
            o_side_middle_last  <= r_sdly[1][PAD];
            o_side_first_last   <= r_sdly[2][PAD];
            o_joint_angle       <= w_ang;
            o_degenerate        <= r_dg[FRNT+32+NST-2];
        end
    end
endmodule
`default_nettype wire
